// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core RTL.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every checked edge
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition must never be seen at a checked edge
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ===== rtl/core/yprgb_pkg.sv =====
`timescale 1ns / 1ps

package yprgb_pkg;

   // Default largest range dimension
   localparam int MAX_DIM_DEFAULT = 1024;

   // Field widths
   localparam int SAMPLE_W   = 8;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int PACKED_W   = 24;
   localparam int OFFSET_W   = 22;
   localparam int ROW_BASE_W = 20;
   localparam int PIX_IDX_W  = ROW_BASE_W + 1;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] STRIDE_RESET = CSR_DATA_W'(512);
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = CSR_DATA_W'(480);
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = CSR_DATA_W'(272);

   // Output packing formats
   typedef enum logic [1:0] {
      MODE_8888 = 2'd0,
      MODE_5650 = 2'd1,
      MODE_5551 = 2'd2,
      MODE_4444 = 2'd3
   } mode_type;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_MODE   = 2'd0,
      CSR_DEST_STRIDE  = 2'd1,
      CSR_RANGE_WIDTH  = 2'd2,
      CSR_RANGE_HEIGHT = 2'd3
   } csr_index_type;

   // Position of one pixel: linear destination index and end-of-range flag
   typedef struct packed {
      logic [PIX_IDX_W-1:0] pixel_index;
      logic                 last;
   } pos_type;

endpackage

// ===== rtl/core/yprgb_position.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module yprgb_position
   import yprgb_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [CSR_DATA_W-1:0] dest_stride,
   input  logic [CSR_DATA_W-1:0] range_width,
   input  logic [CSR_DATA_W-1:0] range_height,
   output pos_type               pos
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int CMP_W = (CNT_W + 1 > CSR_DATA_W) ? CNT_W + 1 : CSR_DATA_W;

   logic [CNT_W-1:0]      col_ff, col_in;
   logic [CNT_W-1:0]      row_ff, row_in;
   logic [ROW_BASE_W-1:0] row_base_ff, row_base_in;
   logic [CMP_W-1:0]      width_eff, height_eff;
   logic                  end_row, end_all;

   // Effective size: zero acts as one, oversize clamps to MAX_DIM
   function automatic logic [CMP_W-1:0] eff_dim(input logic [CSR_DATA_W-1:0] dim);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(dim);
      if (ext == '0) begin
         return CMP_W'(1);
      end else if (ext > CMP_W'(MAX_DIM)) begin
         return CMP_W'(MAX_DIM);
      end
      return ext;
   endfunction

   // End-of-row / end-of-range; a counter past the edge counts as on it
   always_comb begin
      width_eff  = eff_dim(range_width);
      height_eff = eff_dim(range_height);
      end_row    = (CMP_W'(col_ff) + CMP_W'(1)) >= width_eff;
      end_all    = end_row && ((CMP_W'(row_ff) + CMP_W'(1)) >= height_eff);
   end

   // Counter next values
   always_comb begin
      col_in      = col_ff + CNT_W'(1);
      row_in      = row_ff;
      row_base_in = row_base_ff;
      if (end_all) begin
         col_in      = '0;
         row_in      = '0;
         row_base_in = '0;
      end else if (end_row) begin
         col_in      = '0;
         row_in      = row_ff + CNT_W'(1);
         row_base_in = row_base_ff + ROW_BASE_W'(dest_stride);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         row_base_ff <= '0;
      end else if (advance) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         row_base_ff <= row_base_in;
      end
   end

   // Position of the pixel being accepted now
   assign pos.pixel_index = PIX_IDX_W'(row_base_ff) + PIX_IDX_W'(col_ff);
   assign pos.last        = end_all;

   `ASSERT_CLK(a_row_base_held, advance && !end_row |=> $stable(row_base_ff), "row base moved mid-row")

endmodule

// ===== rtl/core/yprgb_color.sv =====
`timescale 1ns / 1ps

module yprgb_color
   import yprgb_pkg::*;
(
   input  logic [SAMPLE_W-1:0] luma_sample,
   input  logic [SAMPLE_W-1:0] cb_sample,
   input  logic [SAMPLE_W-1:0] cr_sample,
   input  mode_type            pixel_mode,
   output logic [PACKED_W-1:0] packed_pixel
);

   localparam int SUM_W = 20;

   logic signed [SUM_W-1:0] c_val, d_val, e_val;
   logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;
   logic [7:0]              r_ch, g_ch, b_ch;

   // Floor-shift by 8 and clamp to 0..255; the rounding constant is added in the sums
   function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] v);
      if (v[SUM_W-1]) begin
         return 8'd0;
      end else if (|v[SUM_W-2:16]) begin
         return 8'hFF;
      end
      return v[15:8];
   endfunction

   // BT.601 studio-swing matrix
   always_comb begin
      c_val = $signed(SUM_W'(luma_sample)) - SUM_W'(16);
      d_val = $signed(SUM_W'(cb_sample)) - SUM_W'(128);
      e_val = $signed(SUM_W'(cr_sample)) - SUM_W'(128);
      r_sum = SUM_W'(298) * c_val + SUM_W'(409) * e_val + SUM_W'(128);
      g_sum = SUM_W'(298) * c_val - SUM_W'(100) * d_val - SUM_W'(208) * e_val
            + SUM_W'(128);
      b_sum = SUM_W'(298) * c_val + SUM_W'(516) * d_val + SUM_W'(128);
      r_ch  = clamp8(r_sum);
      g_ch  = clamp8(g_sum);
      b_ch  = clamp8(b_sum);
   end

   // Pack; alpha stays zero
   always_comb begin
      case (pixel_mode)
         MODE_5650: packed_pixel = {8'd0, b_ch[7:3], g_ch[7:2], r_ch[7:3]};
         MODE_5551: packed_pixel = {8'd0, 1'b0, b_ch[7:3], g_ch[7:3], r_ch[7:3]};
         MODE_4444: packed_pixel = {8'd0, 4'd0, b_ch[7:4], g_ch[7:4], r_ch[7:4]};
         default:   packed_pixel = {b_ch, g_ch, r_ch};
      endcase
   end

endmodule

// ===== rtl/core/ycbcr_to_packed_rgb_converter.sv =====
`timescale 1ns / 1ps
// Throughput: one pixel per clock while rsp_stall is low; the only feedback loop
// is the position counters. Two register stages (input, result) let a new beat
// in while a result waits. Reset (synchronous, active high) empties both stages,
// zeroes the position counters and loads the register defaults (8888, stride
// 512, 480 x 272). The result stage drives rsp.
`include "assert_macros.svh"

module ycbcr_to_packed_rgb_converter
   import yprgb_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_luma_sample,
   input  logic [SAMPLE_W-1:0]   req_cb_sample,
   input  logic [SAMPLE_W-1:0]   req_cr_sample,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PACKED_W-1:0]   rsp_packed_pixel,
   output logic [OFFSET_W-1:0]   rsp_byte_offset,
   output logic                  rsp_last_pixel,
   // register writes
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   mode_type              pixel_mode_ff;
   logic [CSR_DATA_W-1:0] dest_stride_ff, range_width_ff, range_height_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-1:0]   s1_luma_ff, s1_cb_ff, s1_cr_ff;
   logic [OFFSET_W-1:0]   s1_offset_ff, s1_offset_in;
   logic                  s1_last_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PACKED_W-1:0]   rsp_packed_ff, rsp_packed_in;
   logic [OFFSET_W-1:0]   rsp_offset_ff;
   logic                  rsp_last_ff;

   logic                  out_ready, accept;
   pos_type               pos;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff   <= MODE_8888;
         dest_stride_ff  <= STRIDE_RESET;
         range_width_ff  <= WIDTH_RESET;
         range_height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PIXEL_MODE:   pixel_mode_ff   <= mode_type'(csr_write_data[1:0]);
            CSR_DEST_STRIDE:  dest_stride_ff  <= csr_write_data;
            CSR_RANGE_WIDTH:  range_width_ff  <= csr_write_data;
            CSR_RANGE_HEIGHT: range_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Handshake: result stage frees when empty or taken
   always_comb begin
      out_ready    = !rsp_valid_ff || !rsp_stall;
      req_stall    = s1_valid_ff && !out_ready;
      accept       = req_valid && !req_stall;
      s1_valid_in  = accept || (s1_valid_ff && !out_ready);
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   end

   // Position counters advance per accepted beat
   yprgb_position #(
      .MAX_DIM (MAX_DIM)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .dest_stride  (dest_stride_ff),
      .range_width  (range_width_ff),
      .range_height (range_height_ff),
      .pos          (pos)
   );

   // Byte offset: 4 bytes per pixel in 8888, else 2
   always_comb begin
      if (pixel_mode_ff == MODE_8888) begin
         s1_offset_in = {pos.pixel_index[OFFSET_W-3:0], 2'b00};
      end else begin
         s1_offset_in = {pos.pixel_index[OFFSET_W-2:0], 1'b0};
      end
   end

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_luma_ff   <= req_luma_sample;
         s1_cb_ff     <= req_cb_sample;
         s1_cr_ff     <= req_cr_sample;
         s1_offset_ff <= s1_offset_in;
         s1_last_ff   <= pos.last;
      end
   end

   // Color conversion between the two stages
   yprgb_color u_color (
      .luma_sample  (s1_luma_ff),
      .cb_sample    (s1_cb_ff),
      .cr_sample    (s1_cr_ff),
      .pixel_mode   (pixel_mode_ff),
      .packed_pixel (rsp_packed_in)
   );

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_packed_ff <= rsp_packed_in;
         rsp_offset_ff <= s1_offset_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_pixel = rsp_packed_ff;
   assign rsp_byte_offset  = rsp_offset_ff;
   assign rsp_last_pixel   = rsp_last_ff;

   `ASSERT_NEVER(a_stall_needs_full, req_stall && !s1_valid_ff, "input stalled with empty stage")
   `ASSERT_CLK(a_stage_drains, s1_valid_ff && !rsp_valid_ff |=> rsp_valid_ff, "beat lost")
   `ASSERT_CLK(a_offset_even, rsp_valid_ff |-> !rsp_offset_ff[0], "odd byte offset")

endmodule
